>>> hdl/ade_pkg.sv
// Package for the ancestor/descendant exclusion unit.
// Holds sizing constants and opcode/status codes; no dependencies.
`timescale 1ns / 1ps
package ade_pkg;
  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned MaxLinks = 8192;
  localparam int unsigned NodeW    = 10;

  localparam logic [1:0] OpAdd     = 2'd0;
  localparam logic [1:0] OpSuspect = 2'd1;
  localparam logic [1:0] OpQuery   = 2'd2;
  localparam logic [1:0] OpNone    = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StRange   = 2'd2;
endpackage

>>> hdl/ancestor_descendant_exclusion_unit.sv
// Ancestor/descendant exclusion unit: link-list graph store and stack walk.
// Depends on ade_pkg for sizes and codes.
// Out-of-range nodes and unused ops are answered straight from idle; add writes two links;
// query reads the excluded mark; suspect walks up then down links, pushing each new node.
// One item at a time: busy drops in the result cycle. The receiver cannot stall.
// Reset: a clearing pass over all MAX_NODES node records resets heads and marks with
// busy high. Write configuration only while no item is in flight.
`timescale 1ns / 1ps
module ancestor_descendant_exclusion_unit #(
  parameter int unsigned MAX_NODES = ade_pkg::MaxNodes,
  parameter int unsigned MAX_LINKS = ade_pkg::MaxLinks
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [9:0]  child_node_i,
  input  logic [9:0]  parent_node_i,
  input  logic [9:0]  suspect_node_i,
  input  logic [9:0]  query_node_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic        possibly_guilty_o,
  output logic [9:0]  remaining_count_o
);
  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  // Link index width includes the empty marker MAX_LINKS.
  localparam int unsigned LW = $clog2(MAX_LINKS + 1);
  localparam int unsigned TW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int unsigned SW = $clog2(MAX_NODES + 1);
  localparam logic [LW-1:0] Nil = LW'(MAX_LINKS);

  // State codes
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADD1  = 4'd2;
  localparam logic [3:0] S_ADD2  = 4'd3;
  localparam logic [3:0] S_QRY   = 4'd4;
  localparam logic [3:0] S_SUS   = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_HEAD  = 4'd7;
  localparam logic [3:0] S_LINK  = 4'd8;
  localparam logic [3:0] S_MARK  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_SUS2  = 4'd11;
  localparam logic [3:0] S_POPW  = 4'd12;

  // Memories: per-node record {up head, down head, up, down, excluded}
  logic [LW-1:0] uhead_mem [MAX_NODES];
  logic [LW-1:0] dhead_mem [MAX_NODES];
  logic [2:0]    mark_mem  [MAX_NODES];
  logic [NW-1:0] ltgt_mem  [MAX_LINKS];
  logic [LW-1:0] lnxt_mem  [MAX_LINKS];
  logic [NW-1:0] stk_mem   [MAX_NODES];

  logic [3:0]    state_q;
  logic [9:0]    ncount_q;
  logic [LW:0]   lcount_q;
  logic [SW:0]   extot_q;
  logic [NW-1:0] clr_q;
  logic [SW-1:0] sp_q;
  logic          dir_q;       // 0 up walk, 1 down walk
  logic [NW-1:0] node_q, cur_q, tgt_q, child_q;
  logic [LW-1:0] link_q;
  logic          guilty_q;
  logic [1:0]    stat_q;

  // Synchronous read ports
  logic [NW-1:0] nrd_addr;
  logic [LW-1:0] uhead_rd, dhead_rd;
  logic [2:0]    mark_rd;
  logic [TW-1:0] lrd_addr;
  logic [NW-1:0] ltgt_rd;
  logic [LW-1:0] lnxt_rd;
  logic [NW-1:0] stk_rd;

  // Node, link and stack memory write ports
  logic          uh_we, dh_we, mk_we;
  logic [NW-1:0] nwr_addr;
  logic [LW-1:0] uh_wd, dh_wd;
  logic [2:0]    mk_wd;
  logic          lk_we;
  logic [TW-1:0] lwr_addr;
  logic [NW-1:0] ltgt_wd;
  logic [LW-1:0] lnxt_wd;
  logic          st_we;
  logic [NW-1:0] st_wd;

  // Config port
  assign pready = 1'b1;
  assign prdata = {22'd0, ncount_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q <= '0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      ncount_q <= pwdata[9:0];
    end
  end

  function automatic logic valid_node(input logic [9:0] v, input logic [9:0] n);
    valid_node = (v != 10'd0) && (v <= n) && (32'(v) < MAX_NODES);
  endfunction

  assign busy = (state_q != S_IDLE);
  wire accept = start && !busy;

  // Memory access
  always_ff @(posedge clk_i) begin
    if (uh_we) uhead_mem[nwr_addr] <= uh_wd;
    if (dh_we) dhead_mem[nwr_addr] <= dh_wd;
    if (mk_we) mark_mem[nwr_addr] <= mk_wd;
    uhead_rd <= uhead_mem[nrd_addr];
    dhead_rd <= dhead_mem[nrd_addr];
    mark_rd  <= mark_mem[nrd_addr];
    if (lk_we) begin
      ltgt_mem[lwr_addr] <= ltgt_wd;
      lnxt_mem[lwr_addr] <= lnxt_wd;
    end
    ltgt_rd <= ltgt_mem[lrd_addr];
    lnxt_rd <= lnxt_mem[lrd_addr];
    if (st_we) stk_mem[sp_q[NW-1:0]] <= st_wd;
    stk_rd <= stk_mem[NW'(sp_q - SW'(1))];
  end

  logic [3:0]    state_d;
  logic [LW:0]   lcount_d;
  logic [SW:0]   extot_d;
  logic [NW-1:0] clr_d;
  logic [SW-1:0] sp_d;
  logic          dir_d;
  logic [NW-1:0] node_d, cur_d, tgt_d, child_d;
  logic [LW-1:0] link_d;
  logic [1:0]    stat_d;
  logic          guilty_d;
  logic          res_d;
  logic          res_q;
  logic          lv;
  logic          ok_c, ok_p;
  logic [LW-1:0] head_sel;

  always_comb begin
    state_d = state_q; lcount_d = lcount_q; extot_d = extot_q; clr_d = clr_q;
    sp_d = sp_q; dir_d = dir_q; node_d = node_q; cur_d = cur_q; tgt_d = tgt_q;
    child_d = child_q; link_d = link_q; stat_d = stat_q;
    guilty_d = guilty_q; res_d = 1'b0;
    nrd_addr = node_q; lrd_addr = link_q[TW-1:0];
    uh_we = 1'b0; dh_we = 1'b0; mk_we = 1'b0; nwr_addr = node_q;
    uh_wd = Nil; dh_wd = Nil; mk_wd = 3'b000;
    lk_we = 1'b0; lwr_addr = lcount_q[TW-1:0]; ltgt_wd = '0; lnxt_wd = Nil;
    st_we = 1'b0; st_wd = tgt_q;
    ok_c = valid_node(child_node_i, ncount_q);
    ok_p = valid_node(parent_node_i, ncount_q);
    head_sel = dir_q ? dhead_rd : uhead_rd;
    lv = (link_q != Nil) && ({1'b0, link_q} < lcount_q);
    unique case (state_q)
      S_CLR: begin
        uh_we = 1'b1; dh_we = 1'b1; mk_we = 1'b1; nwr_addr = clr_q;
        clr_d = clr_q + NW'(1);
        if (32'(clr_q) == MAX_NODES - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          stat_d = ade_pkg::StOk; guilty_d = 1'b0;
          unique case (op_i)
            ade_pkg::OpAdd: begin
              if (!ok_c || !ok_p) begin
                stat_d = ade_pkg::StRange; res_d = 1'b1;
              end else if (32'(lcount_q) + 2 > MAX_LINKS) begin
                stat_d = ade_pkg::StFull; res_d = 1'b1;
              end else begin
                child_d = NW'(child_node_i); node_d = NW'(parent_node_i);
                nrd_addr = NW'(child_node_i); state_d = S_ADD1;
              end
            end
            ade_pkg::OpSuspect: begin
              if (!valid_node(suspect_node_i, ncount_q)) begin
                stat_d = ade_pkg::StRange; res_d = 1'b1;
              end else begin
                node_d = NW'(suspect_node_i); nrd_addr = NW'(suspect_node_i);
                dir_d = 1'b0; state_d = S_SUS;
              end
            end
            ade_pkg::OpQuery: begin
              if (!valid_node(query_node_i, ncount_q)) begin
                stat_d = ade_pkg::StRange; res_d = 1'b1;
              end else begin
                nrd_addr = NW'(query_node_i); state_d = S_QRY;
              end
            end
            default: res_d = 1'b1;
          endcase
        end
      end
      S_QRY: begin
        guilty_d = !mark_rd[0]; res_d = 1'b1; state_d = S_IDLE;
      end
      S_ADD1: begin
        // child's up list gets link to parent
        lk_we = 1'b1; ltgt_wd = node_q; lnxt_wd = uhead_rd;
        uh_we = 1'b1; nwr_addr = child_q; uh_wd = LW'(lcount_q);
        dh_we = 1'b0;
        lcount_d = lcount_q + (LW+1)'(1);
        nrd_addr = node_q; state_d = S_ADD2;
      end
      S_ADD2: begin
        // read issued last cycle; parent != child or not, head is fresh
        // only if not just written: child head write touches up list only
        lk_we = 1'b1; ltgt_wd = child_q; lnxt_wd = dhead_rd;
        dh_we = 1'b1; nwr_addr = node_q; dh_wd = LW'(lcount_q);
        lcount_d = lcount_q + (LW+1)'(1);
        res_d = 1'b1; state_d = S_IDLE;
      end
      S_SUS: begin
        // mark record of suspect is valid; exclude and test walk mark
        mk_we = 1'b1; nwr_addr = node_q;
        mk_wd = mark_rd | {dir_q ? 1'b0 : 1'b1, dir_q, 1'b1};
        if (!mark_rd[0]) extot_d = extot_q + (SW+1)'(1);
        if ((dir_q ? mark_rd[1] : mark_rd[2])) begin
          state_d = S_SUS2;
        end else begin
          cur_d = node_q; sp_d = '0; state_d = S_HEAD; nrd_addr = node_q;
        end
      end
      S_SUS2: begin
        // second direction; mark written last cycle visible now
        if (dir_q) begin
          res_d = 1'b1; state_d = S_IDLE;
        end else begin
          dir_d = 1'b1; nrd_addr = node_q; state_d = S_SUS;
        end
      end
      S_HEAD: begin
        nrd_addr = cur_q; state_d = S_LINK;
      end
      S_LINK: begin
        // head of cur available; start the link chain there
        state_d = S_MARK; lrd_addr = head_sel[TW-1:0];
        link_d = head_sel;
      end
      S_MARK: begin
        // link data readable; check the link, follow the chain
        if (!lv) begin
          state_d = S_POP;
        end else begin
          tgt_d = ltgt_rd; link_d = lnxt_rd; nrd_addr = ltgt_rd;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // mark record of target valid
        if (!(dir_q ? mark_rd[1] : mark_rd[2])) begin
          mk_we = 1'b1; nwr_addr = tgt_q;
          mk_wd = mark_rd | {dir_q ? 1'b0 : 1'b1, dir_q, 1'b1};
          if (!mark_rd[0]) extot_d = extot_q + (SW+1)'(1);
          if (32'(sp_q) < MAX_NODES) begin
            st_we = 1'b1; sp_d = sp_q + SW'(1);
          end
        end
        lrd_addr = link_q[TW-1:0];
        state_d = S_MARK;
        // issue next link read; the mark write settles before next target read
      end
      S_POP: begin
        if (sp_q == '0) begin
          state_d = S_SUS2;
        end else begin
          sp_d = sp_q - SW'(1); state_d = S_POPW;
        end
      end
      S_POPW: begin
        // stack top read resolves; it becomes the current node
        state_d = S_HEAD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; lcount_q <= '0; extot_q <= '0; clr_q <= '0; sp_q <= '0;
      dir_q <= 1'b0; res_q <= 1'b0;
    end else begin
      state_q <= state_d; lcount_q <= lcount_d; extot_q <= extot_d;
      clr_q <= clr_d; sp_q <= sp_d; dir_q <= dir_d; res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d; tgt_q <= tgt_d; child_q <= child_d;
    link_q <= link_d; stat_q <= stat_d; guilty_q <= guilty_d;
    cur_q <= (state_q == S_POPW) ? stk_rd : cur_d;
  end

  // Result outputs
  assign result_valid_o    = res_q;
  assign status_o          = stat_q;
  assign possibly_guilty_o = guilty_q;
  assign remaining_count_o = ({1'b0, ncount_q} > 11'(extot_q)) ?
                             10'(11'({1'b0, ncount_q}) - 11'(extot_q)) : 10'd0;
endmodule
